@@ rtl/bcm_pkg.sv @@
package bcm_pkg;

  localparam int MAX_WIDTH_DEF = 256;
  localparam int DIM_W = 9;
  localparam logic [DIM_W-1:0] HEIGHT_CAP = 9'd256;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_BORDER = 2'd3;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // one column entry of the line store: {above, center}
  localparam int ENTRY_W = 2;
  localparam logic [ENTRY_W-1:0] ENTRY_WALL = 2'b11;

  typedef struct packed {
    logic drain;
    logic pixel;
    logic row_end;
    logic top_row;
    logic give;
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

endpackage

@@ rtl/bcm_ram.sv @@
module bcm_ram #(
  parameter int Width = 2,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bcm_fifo.sv @@
module bcm_fifo #(
  parameter int Width = 2,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/bcm_front.sv @@
module bcm_front #(
  parameter int MaxWidth = bcm_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_fire_i,
  input  logic                        command_i,
  input  logic                        pixel_wall_i,
  input  logic [bcm_pkg::DIM_W-1:0]   frame_width_i,
  input  logic [bcm_pkg::DIM_W-1:0]   frame_height_i,
  output logic                        q_push_o,
  output logic [$clog2(MaxWidth)-1:0] q_x_o,
  output bcm_pkg::cmd_flags_t         q_flags_o
);
  import bcm_pkg::*;

  localparam int XW = $clog2(MaxWidth);
  localparam int CW = (XW + 2 > DIM_W + 1) ? XW + 2 : DIM_W + 1;

  logic [XW-1:0]    col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [CW-1:0]    fw_ext, eff_w;
  logic [DIM_W-1:0] eff_h;
  logic             drain, row_end, work;

  assign fw_ext = CW'(frame_width_i);
  assign drain  = (command_i == CMD_DRAIN);

  always_comb begin
    if (frame_width_i == '0) begin
      eff_w = CW'(1);
    end else if (fw_ext > CW'(MaxWidth)) begin
      eff_w = CW'(MaxWidth);
    end else begin
      eff_w = fw_ext;
    end
    if (frame_height_i == '0) begin
      eff_h = DIM_W'(1);
    end else if (frame_height_i > HEIGHT_CAP) begin
      eff_h = HEIGHT_CAP;
    end else begin
      eff_h = frame_height_i;
    end
  end

  assign row_end = ((CW'(col_q) + CW'(1)) >= eff_w);
  // drop early drains and pushes past the last row
  assign work    = drain ? (row_q >= eff_h) : (row_q < eff_h);

  assign q_push_o          = in_fire_i & work;
  assign q_x_o             = col_q;
  assign q_flags_o.drain   = drain;
  assign q_flags_o.pixel   = pixel_wall_i;
  assign q_flags_o.row_end = row_end;
  assign q_flags_o.top_row = (row_q == DIM_W'(1));
  assign q_flags_o.give    = drain | (row_q != '0);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (q_push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = drain ? '0 : row_q + DIM_W'(1);
      end else begin
        col_d = col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ rtl/bcm_back.sv @@
module bcm_back #(
  parameter int MaxWidth = bcm_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        mode_i,
  input  logic                        border_i,
  input  logic                        cmd_empty_i,
  input  logic [$clog2(MaxWidth)-1:0] cmd_x_i,
  input  bcm_pkg::cmd_flags_t         cmd_flags_i,
  output logic                        cmd_pop_o,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output logic                        res_wall_o,
  output logic                        res_last_o,
  output logic                        busy_o
);
  import bcm_pkg::*;

  localparam int XW = $clog2(MaxWidth);

  logic [ENTRY_W-1:0] r0_q, r1_q, hold_q;
  logic               left_q;
  logic               clr_q;
  logic [XW-1:0]      clr_cnt_q;
  logic [ENTRY_W-1:0] ent_x, ent_x1, ram_rdata, new_ent;
  logic               fire, is0, is1;
  logic               c, up, down, left, right;
  logic               ram_we;
  logic [XW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign fire = ~cmd_empty_i & ~res_full_i & ~clr_q;
  assign is0  = (cmd_x_i == '0);
  assign is1  = (cmd_x_i == XW'(1));

  // columns 0 and 1 live in flops so a new row can start right after the last
  assign ent_x  = is0 ? r0_q : (is1 ? r1_q : hold_q);
  assign ent_x1 = is0 ? r1_q : ram_rdata;

  assign c     = ent_x[0];
  assign up    = cmd_flags_i.top_row ? border_i : ent_x[1];
  assign left  = is0 ? border_i : left_q;
  assign right = cmd_flags_i.row_end ? border_i : ent_x1[0];
  assign down  = cmd_flags_i.drain ? border_i : cmd_flags_i.pixel;

  assign new_ent = {c, (cmd_flags_i.drain | cmd_flags_i.pixel)};

  assign cmd_pop_o  = fire;
  assign res_push_o = fire & cmd_flags_i.give;
  assign res_wall_o = (mode_i == MODE_DILATE) ? (c | up | down | left | right)
                                              : (c & up & down & left & right);
  assign res_last_o = cmd_flags_i.drain & cmd_flags_i.row_end;
  assign busy_o     = clr_q;

  assign ram_we    = clr_q | (fire & ~is0 & ~is1);
  assign ram_waddr = clr_q ? clr_cnt_q : cmd_x_i;
  assign ram_wdata = clr_q ? ENTRY_WALL : new_ent;

  bcm_ram #(
    .Width (ENTRY_W),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (fire),
    .raddr_i (cmd_x_i + XW'(2)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q      <= ENTRY_WALL;
      r1_q      <= ENTRY_WALL;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      if (fire && is0) begin
        r0_q <= new_ent;
      end
      if (fire && is1) begin
        r1_q <= new_ent;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + XW'(1);
        if (clr_cnt_q == XW'(MaxWidth - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hold_q <= ent_x1;
      left_q <= c;
    end
  end

endmodule

@@ rtl/binary_cross_morphology.sv @@
// Binary erosion / dilation of a raster tile map with the four-neighbor cross.
// Push one pixel per item (command_i = push) in raster order; the result for a
// pixel leaves once the pixel below it is pushed, so the first row gives no
// results and the last row is flushed with one drain item per column. Pushes
// past frame_height rows and drains before that are dropped without a result.
// out_last_o marks the drain of the final column. Neighbors outside the map
// read as border_is_wall. The block takes one item per clock while full is
// low and gives one result per clock while the reader keeps popping: the front
// keeps the column and row counters, a two-entry queue feeds the back, which
// keeps the two line rows in one RAM of MaxWidth two-bit entries (one read and
// one write per cycle) plus two flops for columns 0 and 1, and a two-entry
// result queue parts it from the reader. After reset the whole RAM is filled
// with wall, while full stays high; register writes are taken as usual.
module binary_cross_morphology #(
  parameter int MaxWidth = bcm_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue
  input  logic                          push,
  output logic                          full,
  input  logic                          command_i,
  input  logic                          pixel_wall_i,
  // result queue
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_wall_o,
  output logic                          out_last_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcm_pkg::PADDR_W-1:0]   paddr,
  input  logic [bcm_pkg::PDATA_W-1:0]   pwdata,
  output logic [bcm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bcm_pkg::*;

  localparam int XW = $clog2(MaxWidth);
  localparam int CMD_W = XW + FLAGS_W;
  localparam int RES_W = 2;

  // configuration
  logic             mode_q, border_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;

  // front to queue
  logic             in_fire;
  logic             f_push;
  logic [XW-1:0]    f_x;
  cmd_flags_t       f_flags;

  // queue to back
  logic             cq_full, cq_empty, cq_pop;
  logic [CMD_W-1:0] cq_rdata;
  logic [XW-1:0]    b_x;
  cmd_flags_t       b_flags;

  // back to result queue
  logic             rq_full, res_push, res_wall, res_last, busy;
  logic [RES_W-1:0] rq_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ERODE;
      width_q  <= DIM_W'(64);
      height_q <= DIM_W'(64);
      border_q <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:   mode_q   <= pwdata[0];
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_BORDER: border_q <= pwdata[0];
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:   prdata = PDATA_W'(mode_q);
      REG_WIDTH:  prdata = PDATA_W'(width_q);
      REG_HEIGHT: prdata = PDATA_W'(height_q);
      REG_BORDER: prdata = PDATA_W'(border_q);
      default:    prdata = '0;
    endcase
  end

  // hold off new items while the queue is full or the line RAM is clearing
  assign full    = cq_full | busy;
  assign in_fire = push & ~full;

  bcm_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .command_i      (command_i),
    .pixel_wall_i   (pixel_wall_i),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .q_push_o       (f_push),
    .q_x_o          (f_x),
    .q_flags_o      (f_flags)
  );

  bcm_fifo #(
    .Width (CMD_W),
    .Depth (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_x, f_flags}),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .rdata_o (cq_rdata),
    .empty_o (cq_empty)
  );

  assign b_x     = cq_rdata[CMD_W-1:FLAGS_W];
  assign b_flags = cmd_flags_t'(cq_rdata[FLAGS_W-1:0]);

  bcm_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .border_i    (border_q),
    .cmd_empty_i (cq_empty),
    .cmd_x_i     (b_x),
    .cmd_flags_i (b_flags),
    .cmd_pop_o   (cq_pop),
    .res_full_i  (rq_full),
    .res_push_o  (res_push),
    .res_wall_o  (res_wall),
    .res_last_o  (res_last),
    .busy_o      (busy)
  );

  bcm_fifo #(
    .Width (RES_W),
    .Depth (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i ({res_wall, res_last}),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (rq_rdata),
    .empty_o (empty)
  );

  assign out_wall_o = rq_rdata[1];
  assign out_last_o = rq_rdata[0];

`ifndef SYNTHESIS
  // no item may enter while the line RAM is being cleared
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> full)
    else $error("item path open during line RAM clear");

  // the back never advances into a full result queue
  a_back_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop |-> (!rq_full && !cq_empty))
    else $error("back advanced without room or without an item");

  // the front never pushes into a full queue
  a_front_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_push |-> (!cq_full && in_fire))
    else $error("front pushed into a full queue");
`endif

endmodule
